/* rtl/core/a85e_pkg.sv */
// Shared types and constants for the ASCII85 stream encoder.
package a85e_pkg;

	// Character codes
	localparam logic [6:0] CH_BASE  = 7'd33;
	localparam logic [6:0] CH_NL    = 7'd10;
	localparam logic [6:0] CH_TILDE = 7'd126;
	localparam logic [6:0] CH_GT    = 7'd62;

	localparam logic [7:0] TPL_RESET = 8'd15;
	localparam logic [6:0] RADIX     = 7'd85;

	// floor(w / 85) == (w * RECIP85) >> RECIP_SHIFT for every 32-bit w
	localparam logic [31:0] RECIP85     = 32'd3233857729;
	localparam int          RECIP_SHIFT = 38;
	localparam int          QUOT_W      = 64 - RECIP_SHIFT;

	localparam logic [2:0] TUPLE_DIGITS = 3'd5;
	localparam logic [2:0] DIV_STEPS    = 3'd4;

	// Job queue between front and back
	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CW    = JOBQ_AW + 1;

	// One unit of work for the back end: an optional tuple, then an optional
	// newline, then an optional terminator.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  ndig;   // 0 = no tuple, else 2..5 digits
		logic        nl;
		logic        term;
	} job_t;

endpackage

/* rtl/core/a85e_front.sv */
// Front end: byte packing, line counting and job generation.
module a85e_front import a85e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       end_of_stream,
	input  logic       accept,
	output job_t       job,
	output logic       job_push
);

	logic [7:0]  tpl_q;
	logic [23:0] group_q;
	logic [1:0]  fill_q;
	logic [7:0]  line_q;

	logic [23:0] group_next;
	logic [1:0]  fill_next;
	logic [7:0]  line_inc;
	logic [7:0]  line_next;
	logic        tuple_full;
	logic        has_tuple;
	logic        line_nl;

	always_comb begin
		tuple_full = byte_valid && (fill_q == 2'd3);
		group_next = group_q;
		fill_next  = fill_q;
		if (tuple_full) begin
			group_next = '0;
			fill_next  = '0;
		end else if (byte_valid) begin
			case (fill_q)
				2'd0:    group_next[23:16] = data_byte;
				2'd1:    group_next[15:8]  = data_byte;
				2'd2:    group_next[7:0]   = data_byte;
				default: ;
			endcase
			fill_next = fill_q + 2'd1;
		end

		job.word = tuple_full ? {group_q, data_byte} : {group_next, 8'h00};
		if (tuple_full)
			job.ndig = TUPLE_DIGITS;
		else if (end_of_stream && (fill_next != 2'd0))
			job.ndig = 3'(fill_next) + 3'd1;
		else
			job.ndig = 3'd0;

		has_tuple = (job.ndig != 3'd0);
		line_inc  = line_q + 8'd1;
		line_nl   = (line_inc >= tpl_q);
		job.nl    = has_tuple && line_nl;
		job.term  = end_of_stream;
		job_push  = accept && (has_tuple || end_of_stream);

		if (!has_tuple)
			line_next = line_q;
		else if (line_nl)
			line_next = '0;
		else
			line_next = line_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpl_q   <= TPL_RESET;
			group_q <= '0;
			fill_q  <= '0;
			line_q  <= '0;
		end else begin
			if (cfg_wr_en)
				tpl_q <= cfg_wr_data;
			if (accept) begin
				if (end_of_stream) begin
					group_q <= '0;
					fill_q  <= '0;
					line_q  <= '0;
				end else begin
					group_q <= group_next;
					fill_q  <= fill_next;
					line_q  <= line_next;
				end
			end
		end
	end

endmodule

/* rtl/core/a85e_jobq.sv */
// Short job queue between the front and back ends.
module a85e_jobq import a85e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	job_t               mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q;
	logic [JOBQ_AW-1:0] rd_ptr_q;
	logic [JOBQ_CW-1:0] count_q;

	assign full    = (count_q == JOBQ_CW'(JOBQ_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= JOBQ_CW'(JOBQ_DEPTH))
		else $error("job queue count overflow");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en)
		else $error("job queue written while full");
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !rd_en)
		else $error("job queue read while empty");

endmodule

/* rtl/core/a85e_back.sv */
// Back end: radix-85 digit conversion and character emission.
module a85e_back import a85e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       job_avail,
	output logic       job_pop,
	input  logic       pop,
	output logic       out_valid,
	output logic [6:0] out_char,
	output logic       out_last
);

	typedef enum logic [2:0] {
		EM_IDLE,
		EM_DIG,
		EM_NL,
		EM_TILDE,
		EM_GT,
		EM_END
	} em_state_t;

	// converter
	logic              cv_busy_q;
	logic              cv_phase_q;
	logic [2:0]        cv_it_q;
	logic [31:0]       cv_w_q;
	logic [QUOT_W-1:0] cv_quot_q;
	logic [6:0]        cv_dig_q [5];
	logic [2:0]        cv_ndig_q;
	logic              cv_nl_q;
	logic              cv_term_q;
	logic [63:0]       cv_prod;
	logic [6:0]        cv_rem;
	logic              cv_done;
	logic              handoff;

	// emitter
	em_state_t   em_state_q;
	em_state_t   em_next;
	logic [6:0]  em_dig_q [5];
	logic [2:0]  em_ndig_q;
	logic        em_nl_q;
	logic        em_term_q;
	logic [2:0]  em_pos_q;
	logic [6:0]  em_char;
	logic        em_last;
	logic        advance;
	logic        out_valid_q;
	logic [6:0]  out_char_q;
	logic        out_last_q;

	assign cv_prod = 64'(cv_w_q) * 64'(RECIP85);
	assign cv_rem  = cv_w_q[6:0] - 7'(cv_quot_q[6:0] * RADIX);
	assign cv_done = cv_busy_q && ((cv_ndig_q == 3'd0) || (cv_it_q == DIV_STEPS));
	assign handoff = cv_done && (em_state_q == EM_IDLE);
	assign job_pop = job_avail && (!cv_busy_q || handoff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_busy_q  <= 1'b0;
			cv_phase_q <= 1'b0;
			cv_it_q    <= '0;
		end else if (job_pop) begin
			cv_busy_q  <= 1'b1;
			cv_phase_q <= 1'b0;
			cv_it_q    <= '0;
		end else if (handoff) begin
			cv_busy_q <= 1'b0;
		end else if (cv_busy_q && !cv_done) begin
			cv_phase_q <= !cv_phase_q;
			if (cv_phase_q)
				cv_it_q <= cv_it_q + 3'd1;
		end
	end

	// Digits are produced least significant first: step k leaves digit 4-k.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cv_w_q    <= job.word;
			cv_ndig_q <= job.ndig;
			cv_nl_q   <= job.nl;
			cv_term_q <= job.term;
		end else if (cv_busy_q && !cv_done) begin
			if (!cv_phase_q) begin
				cv_quot_q <= cv_prod[63:RECIP_SHIFT];
			end else begin
				cv_dig_q[DIV_STEPS - cv_it_q] <= cv_rem;
				if (cv_it_q == DIV_STEPS - 3'd1)
					cv_dig_q[0] <= cv_quot_q[6:0];
				cv_w_q <= 32'(cv_quot_q);
			end
		end
	end

	assign advance = (em_state_q != EM_IDLE) && (!out_valid_q || pop);

	always_comb begin
		em_char = CH_NL;
		em_last = 1'b0;
		em_next = em_state_q;
		unique case (em_state_q)
			EM_IDLE: em_next = EM_IDLE;
			EM_DIG: begin
				em_char = em_dig_q[em_pos_q] + CH_BASE;
				if (em_pos_q + 3'd1 == em_ndig_q)
					em_next = em_nl_q ? EM_NL : (em_term_q ? EM_TILDE : EM_IDLE);
			end
			EM_NL:    em_next = em_term_q ? EM_TILDE : EM_IDLE;
			EM_TILDE: begin
				em_char = CH_TILDE;
				em_next = EM_GT;
			end
			EM_GT: begin
				em_char = CH_GT;
				em_next = EM_END;
			end
			EM_END: begin
				em_last = 1'b1;
				em_next = EM_IDLE;
			end
			default: em_next = EM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_state_q  <= EM_IDLE;
			em_pos_q    <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_char_q  <= em_char;
				out_last_q  <= em_last;
				em_state_q  <= em_next;
				if (em_state_q == EM_DIG)
					em_pos_q <= em_pos_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (handoff) begin
				em_state_q <= (cv_ndig_q != 3'd0) ? EM_DIG : EM_TILDE;
				em_pos_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			em_dig_q  <= cv_dig_q;
			em_ndig_q <= cv_ndig_q;
			em_nl_q   <= cv_nl_q;
			em_term_q <= cv_term_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_char_q == CH_NL)
		else $error("last flag on a non-newline character");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance && em_state_q == EM_DIG |=>
			out_char_q >= CH_BASE && out_char_q < CH_BASE + RADIX)
		else $error("digit character out of range");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cv_busy_q |-> cv_it_q <= DIV_STEPS)
		else $error("converter ran past its last step");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		em_state_q == EM_DIG |-> em_pos_q < em_ndig_q)
		else $error("emitter digit position past tuple length");

endmodule

/* rtl/core/ascii85_stream_encoder.sv */
// Top level of the ASCII85 stream encoder: front end, job queue, back end.
// A completed group passes through the job queue, the divide-by-85 steps, the
//   handoff and the output register; a terminator-only item shows '~' first.
// Throughput: one byte per cycle while the job queue has room; the sustained
//   rate is set by the converter (4 divide steps, each a multiply and a remainder
//   phase, plus a handoff); the emitter sends one character per cycle while its output is popped.
// Reset: arst_n clears all control state; tuples_per_line returns to 15.
module ascii85_stream_encoder import a85e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: tuples_per_line
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	// input queue side
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       end_of_stream,
	// result queue side
	output logic       empty,
	input  logic       pop,
	output logic [6:0] out_char,
	output logic       last_char
);

	logic accept;
	job_t front_job;
	logic front_push;
	job_t back_job;
	logic jobq_full;
	logic jobq_empty;
	logic back_pop;
	logic out_valid;

	// An item is transferred whenever the job queue has room; items that
	// produce no job (a byte that does not finish a group) just update the
	// packing state.
	assign accept = push && !full;
	assign full   = jobq_full;

	a85e_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.end_of_stream(end_of_stream),
		.accept       (accept),
		.job          (front_job),
		.job_push     (front_push)
	);

	// Decouples the byte-rate front from the character-rate back.
	a85e_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_push),
		.wr_data(front_job),
		.rd_en  (back_pop),
		.rd_data(back_job),
		.full   (jobq_full),
		.empty  (jobq_empty)
	);

	// Converter and emitter; the emitter's output register is the result
	// queue head, refilled in the same cycle it is popped when the emitter has a next character.
	a85e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (back_job),
		.job_avail(!jobq_empty),
		.job_pop  (back_pop),
		.pop      (pop && !empty),
		.out_valid(out_valid),
		.out_char (out_char),
		.out_last (last_char)
	);

	assign empty = !out_valid;

endmodule
